[src/wpf_pkg.sv]
`timescale 1ns / 1ps
package wpf_pkg;

    localparam int MAX_POINTS = 16;
    localparam int SLOT_W     = 4;
    localparam int LEN_W      = 5;
    localparam int ROOT_STEPS = 25;
    localparam logic [49:0] SNAP_LIMIT = 50'd656;

    localparam logic [1:0] CFG_SPEED   = 2'd0;
    localparam logic [1:0] CFG_LOOPING = 2'd1;
    localparam logic [1:0] CFG_LENGTH  = 2'd2;

    localparam logic [2:0] HEAD_NONE  = 3'd0;
    localparam logic [2:0] HEAD_UP    = 3'd1;
    localparam logic [2:0] HEAD_DOWN  = 3'd2;
    localparam logic [2:0] HEAD_LEFT  = 3'd3;
    localparam logic [2:0] HEAD_RIGHT = 3'd4;

    typedef struct packed {
        logic               action;
        logic [15:0]        delta;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [3:0]         point_index;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [23:0]        point_pause;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] move_x;
        logic signed [23:0] move_y;
        logic               moving;
        logic [2:0]         heading;
        logic               facing_left;
        logic [3:0]         target_slot;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_WRITE, OP_PAUSE, OP_WRAP, OP_DIFF, OP_SQX, OP_SQY,
        OP_SUM, OP_MSTEP, OP_SNAP, OP_HEAD, OP_SQRT, OP_MUL_X, OP_DLOAD, OP_DIV,
        OP_MUL_Y, OP_STORE_Y, OP_FIN
    } dp_op_t;

    typedef struct packed {
        logic is_write;
        logic len_zero;
        logic pause_pending;
        logic done;
        logic slot_beyond;
        logic looping;
        logic snap;
        logic reach;
        logic iter_last;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_WRAP, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_MSTEP,
        ST_CHECK, ST_SQRT, ST_MULX, ST_DLX, ST_DIVX, ST_MULY, ST_DLY, ST_DIVY,
        ST_STY, ST_FIN
    } state_t;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

[src/wpf_ctrl.sv]
`timescale 1ns / 1ps
module wpf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  wpf_pkg::dp_status_t status,
    output wpf_pkg::dp_op_t     op
);

    wpf_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wpf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign s_ready = (state_reg == wpf_pkg::ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        op           = wpf_pkg::OP_NONE;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            wpf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op         = wpf_pkg::OP_LOAD;
                    state_next = wpf_pkg::ST_DISPATCH;
                end
            end
            wpf_pkg::ST_DISPATCH: begin
                state_next = wpf_pkg::ST_FIN;
                if (status.is_write) begin
                    op = wpf_pkg::OP_WRITE;
                end else if (status.len_zero) begin
                    op = wpf_pkg::OP_NONE;
                end else if (status.pause_pending) begin
                    op = wpf_pkg::OP_PAUSE;
                end else if (status.done) begin
                    op = wpf_pkg::OP_NONE;
                end else if (status.slot_beyond) begin
                    state_next = wpf_pkg::ST_WRAP;
                end else begin
                    state_next = wpf_pkg::ST_DIFF;
                end
            end
            wpf_pkg::ST_WRAP: begin
                op         = wpf_pkg::OP_WRAP;
                state_next = status.looping ? wpf_pkg::ST_DIFF : wpf_pkg::ST_FIN;
            end
            wpf_pkg::ST_DIFF: begin
                op         = wpf_pkg::OP_DIFF;
                state_next = wpf_pkg::ST_SQX;
            end
            wpf_pkg::ST_SQX: begin
                op         = wpf_pkg::OP_SQX;
                state_next = wpf_pkg::ST_SQY;
            end
            wpf_pkg::ST_SQY: begin
                op         = wpf_pkg::OP_SQY;
                state_next = wpf_pkg::ST_SUM;
            end
            wpf_pkg::ST_SUM: begin
                op         = wpf_pkg::OP_SUM;
                state_next = wpf_pkg::ST_MSTEP;
            end
            wpf_pkg::ST_MSTEP: begin
                op         = wpf_pkg::OP_MSTEP;
                state_next = wpf_pkg::ST_CHECK;
            end
            wpf_pkg::ST_CHECK: begin
                if (status.snap) begin
                    op         = wpf_pkg::OP_SNAP;
                    state_next = wpf_pkg::ST_FIN;
                end else begin
                    op         = wpf_pkg::OP_HEAD;
                    state_next = status.reach ? wpf_pkg::ST_FIN : wpf_pkg::ST_SQRT;
                end
            end
            wpf_pkg::ST_SQRT: begin
                op = wpf_pkg::OP_SQRT;
                if (status.iter_last) state_next = wpf_pkg::ST_MULX;
            end
            wpf_pkg::ST_MULX: begin
                op         = wpf_pkg::OP_MUL_X;
                state_next = wpf_pkg::ST_DLX;
            end
            wpf_pkg::ST_DLX: begin
                op         = wpf_pkg::OP_DLOAD;
                state_next = wpf_pkg::ST_DIVX;
            end
            wpf_pkg::ST_DIVX: begin
                op = wpf_pkg::OP_DIV;
                if (status.iter_last) state_next = wpf_pkg::ST_MULY;
            end
            wpf_pkg::ST_MULY: begin
                op         = wpf_pkg::OP_MUL_Y;
                state_next = wpf_pkg::ST_DLY;
            end
            wpf_pkg::ST_DLY: begin
                op         = wpf_pkg::OP_DLOAD;
                state_next = wpf_pkg::ST_DIVY;
            end
            wpf_pkg::ST_DIVY: begin
                op = wpf_pkg::OP_DIV;
                if (status.iter_last) state_next = wpf_pkg::ST_STY;
            end
            wpf_pkg::ST_STY: begin
                op         = wpf_pkg::OP_STORE_Y;
                state_next = wpf_pkg::ST_FIN;
            end
            wpf_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    op           = wpf_pkg::OP_FIN;
                    m_valid_next = 1'b1;
                    state_next   = wpf_pkg::ST_IDLE;
                end
            end
            default: state_next = wpf_pkg::ST_IDLE;
        endcase
    end

endmodule

[src/wpf_datapath.sv]
`timescale 1ns / 1ps
module wpf_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [22:0]         cfg_data,
    input  wpf_pkg::in_item_t   s_data,
    input  wpf_pkg::dp_op_t     op,
    output wpf_pkg::dp_status_t status,
    output wpf_pkg::out_item_t  m_data
);

    logic [22:0] speed_reg;
    logic        looping_reg;
    logic [4:0]  length_reg;

    logic signed [23:0] wx_reg [wpf_pkg::MAX_POINTS];
    logic signed [23:0] wy_reg [wpf_pkg::MAX_POINTS];
    logic [23:0]        wp_reg [wpf_pkg::MAX_POINTS];

    logic [3:0]  slot_reg;
    logic [23:0] pause_reg;
    logic [2:0]  heading_reg;
    logic        facing_reg;
    logic        done_reg;

    wpf_pkg::in_item_t  item_reg;
    wpf_pkg::out_item_t res_reg;
    logic signed [23:0] mx_reg, my_reg;
    logic               mv_reg;

    logic signed [24:0] dx_reg, dy_reg;
    logic [24:0]        ax_reg, ay_reg;
    logic [49:0]        prod_reg, s_reg;
    logic [22:0]        m_reg;
    logic [49:0]        v_reg, r_reg;
    logic [4:0]         k_reg;
    logic [24:0]        rem_reg, q_reg;

    logic [4:0]  len;
    logic [24:0] mul_a, mul_b;
    logic [49:0] prod_next;
    logic [49:0] bit_val, rb;
    logic [25:0] trial;
    logic [24:0] d_val;
    logic [4:0]  slot_inc;
    logic signed [25:0] qx_signed, qy_signed;
    logic signed [24:0] diff_x, diff_y;

    assign len      = (length_reg > 5'(wpf_pkg::MAX_POINTS)) ? 5'(wpf_pkg::MAX_POINTS)
                                                             : length_reg;
    assign bit_val  = 50'd1 << {k_reg, 1'b0};
    assign rb       = r_reg + bit_val;
    assign d_val    = r_reg[24:0];
    assign trial    = {rem_reg, q_reg[24]};
    assign slot_inc = {1'b0, slot_reg} + 5'd1;
    assign qx_signed = dx_reg[24] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign qy_signed = dy_reg[24] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign diff_x   = 25'(wx_reg[slot_reg]) - 25'(item_reg.pos_x);
    assign diff_y   = 25'(wy_reg[slot_reg]) - 25'(item_reg.pos_y);

    always_comb begin
        mul_a = ax_reg;
        mul_b = ax_reg;
        case (op)
            wpf_pkg::OP_SQY: begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            wpf_pkg::OP_SUM: begin
                mul_a = {2'b0, speed_reg};
                mul_b = {9'b0, item_reg.delta};
            end
            wpf_pkg::OP_MSTEP: begin
                mul_a = {2'b0, prod_reg[38:16]};
                mul_b = {2'b0, prod_reg[38:16]};
            end
            wpf_pkg::OP_MUL_X: begin
                mul_a = ax_reg;
                mul_b = {2'b0, m_reg};
            end
            wpf_pkg::OP_MUL_Y: begin
                mul_a = ay_reg;
                mul_b = {2'b0, m_reg};
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb begin
        status.is_write      = item_reg.action;
        status.len_zero      = (len == 5'd0);
        status.pause_pending = (pause_reg != 24'd0);
        status.done          = done_reg;
        status.slot_beyond   = ({1'b0, slot_reg} >= len);
        status.looping       = looping_reg;
        status.snap          = (s_reg < wpf_pkg::SNAP_LIMIT);
        status.reach         = (prod_reg >= s_reg);
        status.iter_last     = (k_reg == 5'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= '0;
            looping_reg <= 1'b0;
            length_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wpf_pkg::CFG_SPEED:   speed_reg   <= cfg_data;
                wpf_pkg::CFG_LOOPING: looping_reg <= cfg_data[0];
                wpf_pkg::CFG_LENGTH:  length_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (op == wpf_pkg::OP_WRITE) begin
            wx_reg[item_reg.point_index] <= item_reg.point_x;
            wy_reg[item_reg.point_index] <= item_reg.point_y;
            wp_reg[item_reg.point_index] <= item_reg.point_pause;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            pause_reg   <= '0;
            heading_reg <= wpf_pkg::HEAD_NONE;
            facing_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            case (op)
                wpf_pkg::OP_PAUSE: begin
                    pause_reg <= (pause_reg > {8'd0, item_reg.delta})
                               ? pause_reg - {8'd0, item_reg.delta} : 24'd0;
                end
                wpf_pkg::OP_WRAP: begin
                    if (looping_reg) begin
                        slot_reg <= '0;
                    end else begin
                        done_reg    <= 1'b1;
                        heading_reg <= wpf_pkg::HEAD_NONE;
                    end
                end
                wpf_pkg::OP_SNAP: begin
                    pause_reg <= wp_reg[slot_reg];
                    if (slot_inc >= len) begin
                        if (looping_reg) begin
                            slot_reg <= '0;
                        end else begin
                            slot_reg    <= slot_inc[3:0];
                            done_reg    <= 1'b1;
                            heading_reg <= wpf_pkg::HEAD_NONE;
                        end
                    end else begin
                        slot_reg <= slot_inc[3:0];
                    end
                end
                wpf_pkg::OP_HEAD: begin
                    if (ax_reg > ay_reg) begin
                        heading_reg <= (dx_reg > 0) ? wpf_pkg::HEAD_RIGHT : wpf_pkg::HEAD_LEFT;
                        facing_reg  <= !(dx_reg > 0);
                    end else begin
                        heading_reg <= (dy_reg > 0) ? wpf_pkg::HEAD_DOWN : wpf_pkg::HEAD_UP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            wpf_pkg::OP_LOAD: begin
                item_reg <= s_data;
                mx_reg   <= '0;
                my_reg   <= '0;
                mv_reg   <= 1'b0;
            end
            wpf_pkg::OP_DIFF: begin
                dx_reg <= diff_x;
                dy_reg <= diff_y;
                ax_reg <= diff_x[24] ? -diff_x : diff_x;
                ay_reg <= diff_y[24] ? -diff_y : diff_y;
            end
            default: ;
        endcase
        case (op)
            wpf_pkg::OP_SQX: prod_reg <= prod_next;
            wpf_pkg::OP_SQY: begin
                s_reg    <= prod_reg;
                prod_reg <= prod_next;
            end
            wpf_pkg::OP_SUM: begin
                s_reg    <= s_reg + prod_reg;
                prod_reg <= prod_next;
            end
            wpf_pkg::OP_MSTEP: begin
                m_reg    <= prod_reg[38:16];
                prod_reg <= prod_next;
            end
            wpf_pkg::OP_SNAP: begin
                mx_reg <= wpf_pkg::sat24(26'(dx_reg));
                my_reg <= wpf_pkg::sat24(26'(dy_reg));
            end
            wpf_pkg::OP_HEAD: begin
                mv_reg <= 1'b1;
                mx_reg <= wpf_pkg::sat24(26'(dx_reg));
                my_reg <= wpf_pkg::sat24(26'(dy_reg));
                v_reg  <= s_reg;
                r_reg  <= '0;
                k_reg  <= 5'(wpf_pkg::ROOT_STEPS - 1);
            end
            wpf_pkg::OP_SQRT: begin
                if (v_reg >= rb) begin
                    v_reg <= v_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_val;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                if (k_reg != 5'd0) k_reg <= k_reg - 5'd1;
            end
            wpf_pkg::OP_MUL_X: begin
                prod_reg <= prod_next;
                m_reg    <= m_reg;
                v_reg    <= {25'd0, d_val};
            end
            wpf_pkg::OP_MUL_Y: begin
                prod_reg <= prod_next;
                mx_reg   <= wpf_pkg::sat24(qx_signed);
            end
            wpf_pkg::OP_DLOAD: begin
                rem_reg <= {2'b0, prod_reg[47:25]};
                q_reg   <= prod_reg[24:0];
                k_reg   <= 5'(wpf_pkg::ROOT_STEPS - 1);
            end
            wpf_pkg::OP_DIV: begin
                if (trial >= {1'b0, v_reg[24:0]}) begin
                    rem_reg <= 25'(trial - {1'b0, v_reg[24:0]});
                    q_reg   <= {q_reg[23:0], 1'b1};
                end else begin
                    rem_reg <= trial[24:0];
                    q_reg   <= {q_reg[23:0], 1'b0};
                end
                if (k_reg != 5'd0) k_reg <= k_reg - 5'd1;
            end
            wpf_pkg::OP_STORE_Y: my_reg <= wpf_pkg::sat24(qy_signed);
            wpf_pkg::OP_FIN: begin
                res_reg.move_x      <= mx_reg;
                res_reg.move_y      <= my_reg;
                res_reg.moving      <= mv_reg;
                res_reg.heading     <= heading_reg;
                res_reg.facing_left <= facing_reg;
                res_reg.target_slot <= slot_reg;
            end
            default: ;
        endcase
    end

    assign m_data = res_reg;

endmodule

[src/waypoint_path_follower_core.sv]
`timescale 1ns / 1ps
// Waypoint path follower.
// Input channel s_valid/s_ready/s_data carries either a waypoint write
// (action 1) or a time tick (action 0); every transaction yields one result
// transaction on m_valid/m_ready/m_data.
// Configuration (speed, looping, path_length) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. A write, an empty path, a
// pause countdown or a finished path goes from dispatch straight to the
// result; a snap or a step that reaches the waypoint also passes through the
// difference, squaring, sum, step and check states; a scaled step adds the
// 25-step square root and two 25-step divisions on the shared multiplier
// datapath. One item is in work at a time. The result sits in an output
// register: the next item is taken while it waits, and a stalled receiver
// only holds the block at the end of the following item.
// Reset (aresetn low, synchronous) clears the settings, slot, pause, heading,
// facing and finished flag; the waypoint table is undefined until written.
module waypoint_path_follower_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  wpf_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wpf_pkg::out_item_t m_data
);

    wpf_pkg::dp_op_t     op;
    wpf_pkg::dp_status_t status;

    wpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .op      (op)
    );

    wpf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .op        (op),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   IN_W = $bits(wpf_pkg::in_item_t);

    class path_scoreboard;
        longint          way_x[wpf_pkg::MAX_POINTS];
        longint          way_y[wpf_pkg::MAX_POINTS];
        int unsigned     way_pause[wpf_pkg::MAX_POINTS];
        int unsigned     slot, pause_left, heading, spd, path_len;
        bit              facing_left, done, looping;
        wpf_pkg::out_item_t pending[$];
        int              errors, checked;

        function new();
            slot = 0; pause_left = 0; heading = wpf_pkg::HEAD_NONE; facing_left = 0;
            done = 0; spd = 0; looping = 0; path_len = 0; errors = 0; checked = 0;
        endfunction

        function int unsigned eff_len();
            return (path_len > wpf_pkg::MAX_POINTS) ? wpf_pkg::MAX_POINTS : path_len;
        endfunction

        function int unsigned aim_slot();
            return (slot >= eff_len()) ? 0 : slot;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint scaled(longint c, longint unsigned m, longint unsigned d);
            longint unsigned q;
            q = ((c < 0) ? -c : c) * m / d;
            return (c < 0) ? -longint'(q) : longint'(q);
        endfunction

        function logic [23:0] clip24(longint v);
            if (v > 8388607) return 24'h7FFFFF;
            if (v < -8388608) return 24'h800000;
            return v[23:0];
        endfunction

        function void note_item(wpf_pkg::in_item_t it);
            longint          mx, my, dx, dy;
            longint unsigned ax, ay, s, m;
            bit              mv;
            int unsigned     len;
            wpf_pkg::out_item_t r;
            mx = 0; my = 0; mv = 0;
            len = eff_len();
            if (it.action == ACT_WRITE) begin
                way_x[it.point_index]     = $signed(it.point_x);
                way_y[it.point_index]     = $signed(it.point_y);
                way_pause[it.point_index] = it.point_pause;
            end else if (len != 0) begin
                if (pause_left > 0) begin
                    pause_left = (pause_left > it.delta) ? pause_left - it.delta : 0;
                end else if (!done) begin
                    if (slot >= len) begin
                        if (looping) slot = 0;
                        else begin done = 1; heading = wpf_pkg::HEAD_NONE; end
                    end
                    if (!done) begin
                        dx = way_x[slot] - longint'($signed(it.pos_x));
                        dy = way_y[slot] - longint'($signed(it.pos_y));
                        ax = (dx < 0) ? -dx : dx;
                        ay = (dy < 0) ? -dy : dy;
                        s  = ax * ax + ay * ay;
                        if (s * 100 < 65536) begin
                            mx = dx; my = dy;
                            pause_left = way_pause[slot];
                            slot++;
                            if (slot >= len) begin
                                if (looping) slot = 0;
                                else begin done = 1; heading = wpf_pkg::HEAD_NONE; end
                            end
                        end else begin
                            m = (longint'(spd) * it.delta) >> 16;
                            if (ax > ay) begin
                                heading = (dx > 0) ? wpf_pkg::HEAD_RIGHT : wpf_pkg::HEAD_LEFT;
                            end else begin
                                heading = (dy > 0) ? wpf_pkg::HEAD_DOWN : wpf_pkg::HEAD_UP;
                            end
                            if (m * m >= s) begin
                                mx = dx; my = dy;
                            end else begin
                                mx = scaled(dx, m, isqrt(s));
                                my = scaled(dy, m, isqrt(s));
                            end
                            mv = 1;
                            if (heading == wpf_pkg::HEAD_LEFT) facing_left = 1;
                            else if (heading == wpf_pkg::HEAD_RIGHT) facing_left = 0;
                        end
                    end
                end
            end
            r.move_x      = clip24(mx);
            r.move_y      = clip24(my);
            r.moving      = mv;
            r.heading     = heading[2:0];
            r.facing_left = facing_left;
            r.target_slot = slot[3:0];
            pending.push_back(r);
        endfunction

        function void check_result(wpf_pkg::out_item_t got);
            wpf_pkg::out_item_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.move_x !== exp.move_x || got.move_y !== exp.move_y ||
                got.moving !== exp.moving || got.heading !== exp.heading ||
                got.facing_left !== exp.facing_left ||
                got.target_slot !== exp.target_slot) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = wpf_pkg::CFG_SPEED;
    logic [22:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    wpf_pkg::in_item_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    wpf_pkg::out_item_t m_data;

    path_scoreboard sb = new();
    bit  quiet = 0;
    int  idle_cycles = 0;
    int  ticks_sent = 0, writes_sent = 0;

    waypoint_path_follower_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send(wpf_pkg::in_item_t it);
        if (!quiet && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        if (it.action == ACT_WRITE) writes_sent++;
        else ticks_sent++;
    endtask

    task automatic settle();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [22:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            wpf_pkg::CFG_SPEED:   sb.spd = val;
            wpf_pkg::CFG_LOOPING: sb.looping = val[0];
            wpf_pkg::CFG_LENGTH:  sb.path_len = val[4:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_point(int idx, logic [23:0] x, logic [23:0] y, logic [23:0] p);
        wpf_pkg::in_item_t it;
        it = wpf_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        it.action      = ACT_WRITE;
        it.point_index = idx[3:0];
        it.point_x     = x;
        it.point_y     = y;
        it.point_pause = p;
        send(it);
    endtask

    function automatic wpf_pkg::in_item_t make_tick();
        wpf_pkg::in_item_t it;
        int unsigned k;
        longint      wx, wy;
        it = wpf_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        it.action = ACT_TICK;
        k  = $urandom_range(99);
        wx = sb.way_x[sb.aim_slot()];
        wy = sb.way_y[sb.aim_slot()];
        if (k < 30) begin
            it.pos_x = wx[23:0];
            it.pos_y = wy[23:0];
        end else if (k < 45) begin
            it.pos_x = 24'(wx + $signed($urandom_range(36)) - 18);
            it.pos_y = 24'(wy + $signed($urandom_range(36)) - 18);
        end else if (k < 75) begin
            it.pos_x = 24'(wx + $signed($urandom_range(8000)) - 4000);
            it.pos_y = 24'(wy + $signed($urandom_range(8000)) - 4000);
        end
        if ($urandom_range(9) == 0) it.delta = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return it;
    endfunction

    task automatic random_phase(int n);
        logic [23:0] x, y;
        repeat (n) begin
            if ($urandom_range(99) < 12) begin
                x = ($urandom_range(9) == 0) ? 24'($urandom)
                                             : 24'($signed($urandom_range(4000)) - 2000);
                y = ($urandom_range(9) == 0) ? 24'($urandom)
                                             : 24'($signed($urandom_range(4000)) - 2000);
                write_point($urandom_range(wpf_pkg::MAX_POINTS - 1), x, y,
                            ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(60000)));
            end else begin
                send(make_tick());
            end
        end
    endtask

    initial begin
        wpf_pkg::in_item_t it;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // table load with extreme coordinates and pauses
        write_point(0, 24'h800000, 24'h7FFFFF, 24'd0);
        write_point(1, 24'h7FFFFF, 24'h800000, 24'd300);
        write_point(15, 24'd100, 24'd100, 24'hFFFFFF);
        for (int i = 2; i < 15; i++)
            write_point(i, 24'($signed($urandom_range(4000)) - 2000),
                        24'($signed($urandom_range(4000)) - 2000), 24'($urandom_range(20000)));
        // empty path: ticks do nothing
        send(make_tick());
        send(make_tick());
        write_point(15, 24'd0, 24'd0, 24'd1000);

        // long extreme hop, then snap onto the waypoint
        set_reg(wpf_pkg::CFG_SPEED, 23'h7FFFFF);
        set_reg(wpf_pkg::CFG_LOOPING, 23'd1);
        set_reg(wpf_pkg::CFG_LENGTH, 23'd16);
        it = make_tick();
        it.pos_x = 24'h7FFFFF; it.pos_y = 24'h800000; it.delta = 16'hFFFF;
        send(it);
        it.pos_x = 24'h000000; it.pos_y = 24'h000000; it.delta = 16'h0001;
        send(it);
        it.pos_x = 24'h800000; it.pos_y = 24'h7FFFFF;
        send(it);

        set_reg(wpf_pkg::CFG_SPEED, 23'd4096);
        random_phase(250);
        // shrink the path while the target slot may lie past the end
        set_reg(wpf_pkg::CFG_LENGTH, 23'd3);
        random_phase(150);
        quiet = 1;
        set_reg(wpf_pkg::CFG_LENGTH, 23'd31);
        set_reg(wpf_pkg::CFG_SPEED, 23'h7FFFFF);
        random_phase(150);
        quiet = 0;
        set_reg(wpf_pkg::CFG_SPEED, 23'd0);
        random_phase(100);
        set_reg(wpf_pkg::CFG_LENGTH, 23'd0);
        random_phase(50);
        set_reg(wpf_pkg::CFG_SPEED, 23'd2000);
        set_reg(wpf_pkg::CFG_LENGTH, 23'd4);
        set_reg(wpf_pkg::CFG_LOOPING, 23'd0);
        random_phase(200);

        settle();
        repeat (200) @(posedge aclk);
        $display("Covered %0d ticks and %0d waypoint writes; %0d results checked, %0d bad.",
                 ticks_sent, writes_sent, sb.checked, sb.errors);
        $display("Phases: empty, looping, shortened, oversized length, zero and full speed, finished path.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d results never arrived", sb.pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
